// ===== sv/vhs_pkg.sv =====
// Shared types, widths, codes and reset values for the VAD hysteresis segmenter.
// No dependencies; every other file of the block imports this package.
package vhs_pkg;

    // Field widths fixed by the item formats
    localparam int PROB_W      = 13;
    localparam int WIN_W       = 5;
    localparam int HANG_W      = 16;
    localparam int MINLEN_W    = 16;
    localparam int MAXLEN_W    = 20;
    localparam int SEG_W       = 32;
    localparam int CAUSE_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // Parameter defaults
    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_FRAME_BITS = 32;

    // Hangover used when the register holds zero
    localparam logic [HANG_W-1:0] DEFAULT_HANGOVER = HANG_W'(30);

    // Request codes
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Segment cause codes
    localparam logic [CAUSE_W-1:0] CAUSE_HANGOVER = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MAXLEN   = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FLUSH    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HANGOVER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEECH = 3'd5;

    // Configuration register reset values
    localparam logic [PROB_W-1:0]   RST_ENTER_THR  = PROB_W'(2048);
    localparam logic [PROB_W-1:0]   RST_EXIT_THR   = PROB_W'(1434);
    localparam logic [WIN_W-1:0]    RST_SMOOTH_WIN = WIN_W'(1);
    localparam logic [HANG_W-1:0]   RST_HANGOVER   = HANG_W'(0);
    localparam logic [MINLEN_W-1:0] RST_MIN_SPEECH = MINLEN_W'(25);
    localparam logic [MAXLEN_W-1:0] RST_MAX_SPEECH = MAXLEN_W'(0);

    typedef struct packed {
        logic [PROB_W-1:0]   enter_threshold;
        logic [PROB_W-1:0]   exit_threshold;
        logic [WIN_W-1:0]    smooth_window;
        logic [HANG_W-1:0]   hangover_frames;
        logic [MINLEN_W-1:0] min_speech_frames;
        logic [MAXLEN_W-1:0] max_speech_frames;
    } t_vhs_cfg;

    // One classified item between front and back
    typedef struct packed {
        logic              req_type;
        logic [PROB_W-1:0] prob;
    } t_vhs_item;

endpackage

// ===== sv/vhs_if.sv =====
// Channel interfaces of the VAD hysteresis segmenter: input, result and config write.
// Depends on vhs_pkg for field widths.
interface vhs_in_if import vhs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [PROB_W-1:0] prob;

    modport source (output valid, output req_type, output prob, input ready);
    modport sink   (input valid, input req_type, input prob, output ready);
endinterface

interface vhs_out_if import vhs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SEG_W-1:0]   seg_start;
    logic [SEG_W-1:0]   seg_end;
    logic [CAUSE_W-1:0] seg_cause;

    modport source (output valid, output seg_start, output seg_end, output seg_cause,
                    input ready);
    modport sink   (input valid, input seg_start, input seg_end, input seg_cause,
                    output ready);
endinterface

interface vhs_cfg_if import vhs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/vhs_front.sv =====
// Front end: accepts items, keeps the probability history and computes the smoothed value
// (serial sum over the history memory, then a restoring divider). Depends on vhs_pkg.
module vhs_front import vhs_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_vhs_cfg  i_cfg,
    input  logic      i_valid,
    input  t_vhs_item i_item,
    output logic      o_ready,
    output logic      o_push,
    output t_vhs_item o_push_item,
    input  logic      i_full
);

    localparam int HW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = PROB_W + $clog2(MAX_WINDOW);
    localparam int XW    = ((CW > WIN_W) ? CW : WIN_W) + 1;
    localparam int CNT_W = $clog2(((SW > MAX_WINDOW) ? SW : MAX_WINDOW) + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [HW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_n, n_n;
    logic [HW-1:0]     r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SW-1:0]     r_sum, n_sum;
    logic [SW-1:0]     r_div, n_div;
    logic [CW-1:0]     r_rem, n_rem;
    logic [PROB_W-1:0] r_rd_data;
    logic [PROB_W-1:0] r_hist [MAX_WINDOW];

    logic              accept;
    logic              smooth_on;
    logic [XW-1:0]     win_x;
    logic [XW-1:0]     win_sat_x;
    logic [CW:0]       n_cand;
    logic [CW:0]       rem_sh;
    logic              ge;
    logic [CW:0]       rem_sub;
    logic [SW-1:0]     sum_add;

    assign o_ready   = (r_state == ST_IDLE) && !i_full;
    assign accept    = i_valid && o_ready;
    assign smooth_on = i_cfg.smooth_window > WIN_W'(1);

    // Clamp the window to the history depth and grow the fill count by one
    assign win_x     = XW'(i_cfg.smooth_window);
    assign win_sat_x = (win_x > XW'(MAX_WINDOW)) ? XW'(MAX_WINDOW) : win_x;
    assign n_cand    = {1'b0, r_count} + (CW + 1)'(1);

    // One restoring divide step
    assign rem_sh  = {r_rem, r_div[SW-1]};
    assign ge      = rem_sh >= {1'b0, r_n};
    assign rem_sub = rem_sh - {1'b0, r_n};

    assign sum_add = r_sum + SW'(r_rd_data);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_n         = r_n;
        n_rd_idx    = r_rd_idx;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_div       = r_div;
        n_rem       = r_rem;
        o_push      = 1'b0;
        o_push_item = i_item;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.req_type == REQ_FRAME && smooth_on) begin
                        // Store the sample, then walk back over the newest entries
                        n_head   = (r_head == HW'(MAX_WINDOW - 1)) ? '0 : r_head + HW'(1);
                        if (n_cand > (CW + 1)'(win_sat_x)) begin
                            n_count = CW'(win_sat_x);
                        end else begin
                            n_count = n_cand[CW-1:0];
                        end
                        n_n      = n_count;
                        n_rd_idx = r_head;
                        n_cnt    = '0;
                        n_sum    = '0;
                        n_state  = ST_SUM;
                    end else begin
                        // Raw frame or flush goes straight to the queue
                        o_push = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                n_rd_idx = (r_rd_idx == '0) ? HW'(MAX_WINDOW - 1) : r_rd_idx - HW'(1);
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    n_sum = sum_add;
                end
                if (r_cnt == CNT_W'(r_n)) begin
                    n_div   = sum_add;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_div = {r_div[SW-2:0], ge};
                n_rem = ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SW - 1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_push_item.req_type = REQ_FRAME;
                o_push_item.prob     = r_div[PROB_W-1:0];
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_rd_idx <= n_rd_idx;
        r_cnt    <= n_cnt;
        r_sum    <= n_sum;
        r_div    <= n_div;
        r_rem    <= n_rem;
    end

    // History memory: write a smoothed frame's sample on accept, registered read while summing
    always_ff @(posedge i_clk) begin
        if (accept && i_item.req_type == REQ_FRAME && smooth_on) begin
            r_hist[r_head] <= i_item.prob;
        end
        r_rd_data <= r_hist[r_rd_idx];
    end

endmodule

// ===== sv/vhs_queue.sv =====
// Two-beat queue between the front end and the segment machine.
// Depends on vhs_pkg for the item type.
module vhs_queue import vhs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_vhs_item i_push_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_vhs_item o_item
);

    logic [1:0] r_fill;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    t_vhs_item  r_slot [2];

    assign o_full  = r_fill == 2'd2;
    assign o_valid = r_fill != 2'd0;
    assign o_item  = r_slot[r_rd_ptr];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== sv/vhs_back.sv =====
// Segment machine: silence / speech / trailing with hysteresis, hangover, split and flush,
// and the result register. Depends on vhs_pkg.
module vhs_back import vhs_pkg::*; #(
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_vhs_cfg           i_cfg,
    input  logic               i_q_valid,
    input  t_vhs_item          i_q_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [SEG_W-1:0]   o_seg_start,
    output logic [SEG_W-1:0]   o_seg_end,
    output logic [CAUSE_W-1:0] o_seg_cause
);

    localparam int CMP_W = (FRAME_BITS > MAXLEN_W) ? FRAME_BITS : MAXLEN_W;

    localparam logic [1:0] MODE_SILENCE  = 2'd0;
    localparam logic [1:0] MODE_SPEECH   = 2'd1;
    localparam logic [1:0] MODE_TRAILING = 2'd2;

    logic [1:0]            r_mode, n_mode;
    logic [HANG_W-1:0]     r_sil, n_sil;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [FRAME_BITS-1:0] r_start, n_start;
    logic [FRAME_BITS-1:0] r_end, n_end;
    logic                  r_out_valid;
    logic [SEG_W-1:0]      r_seg_start;
    logic [SEG_W-1:0]      r_seg_end;
    logic [CAUSE_W-1:0]    r_seg_cause;

    logic [1:0]            mode_eff;
    logic [FRAME_BITS-1:0] len_now;
    logic [FRAME_BITS-1:0] len_seg;
    logic                  now_long_enough;
    logic                  seg_long_enough;
    logic                  split_due;
    logic                  speech;
    logic [HANG_W-1:0]     limit;
    logic [HANG_W-1:0]     sil_inc;
    logic                  emit;
    logic [FRAME_BITS-1:0] e_start;
    logic [FRAME_BITS-1:0] e_end;
    logic [CAUSE_W-1:0]    e_cause;

    assign o_pop       = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_seg_start = r_seg_start;
    assign o_seg_end   = r_seg_end;
    assign o_seg_cause = r_seg_cause;

    // Lengths and threshold tests
    assign mode_eff = (r_mode == MODE_SPEECH || r_mode == MODE_TRAILING) ? r_mode
                                                                          : MODE_SILENCE;
    assign len_now  = r_frame - r_start;
    assign len_seg  = r_end - r_start;
    assign now_long_enough = CMP_W'(len_now) >= CMP_W'(i_cfg.min_speech_frames);
    assign seg_long_enough = CMP_W'(len_seg) >= CMP_W'(i_cfg.min_speech_frames);
    assign split_due = (mode_eff == MODE_SPEECH) && (i_cfg.max_speech_frames != '0) &&
                       (CMP_W'(len_now) >= CMP_W'(i_cfg.max_speech_frames));
    assign speech = (mode_eff == MODE_SILENCE) ? (i_q_item.prob >= i_cfg.enter_threshold)
                                               : (i_q_item.prob >= i_cfg.exit_threshold);
    assign limit   = (i_cfg.hangover_frames != '0) ? i_cfg.hangover_frames : DEFAULT_HANGOVER;
    assign sil_inc = (r_sil == '1) ? r_sil : r_sil + HANG_W'(1);

    always_comb begin
        n_mode  = r_mode;
        n_sil   = r_sil;
        n_frame = r_frame;
        n_start = r_start;
        n_end   = r_end;
        emit    = 1'b0;
        e_start = r_start;
        e_end   = r_frame;
        e_cause = CAUSE_FLUSH;

        if (o_pop) begin
            if (i_q_item.req_type == REQ_FLUSH) begin
                // Close an open segment at the current frame count
                if (mode_eff != MODE_SILENCE) begin
                    emit   = now_long_enough;
                    n_mode = MODE_SILENCE;
                end
            end else begin
                n_mode = mode_eff;
                if (split_due) begin
                    emit    = 1'b1;
                    e_cause = CAUSE_MAXLEN;
                    n_start = r_frame;
                    n_end   = r_frame;
                end
                case (mode_eff)
                    MODE_SPEECH: begin
                        if (!speech) begin
                            n_mode = MODE_TRAILING;
                            n_sil  = HANG_W'(1);
                        end
                        n_end = r_frame;
                    end
                    MODE_TRAILING: begin
                        if (speech) begin
                            n_mode = MODE_SPEECH;
                            n_sil  = '0;
                        end else begin
                            n_sil = sil_inc;
                            if (sil_inc >= limit) begin
                                emit    = seg_long_enough;
                                e_end   = r_end;
                                e_cause = CAUSE_HANGOVER;
                                n_mode  = MODE_SILENCE;
                            end
                        end
                    end
                    default: begin
                        if (speech) begin
                            n_mode  = MODE_SPEECH;
                            n_start = r_frame;
                            n_sil   = '0;
                        end
                    end
                endcase
                n_frame = r_frame + FRAME_BITS'(1);
            end
        end
    end

    // Machine state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SILENCE;
            r_sil       <= '0;
            r_frame     <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_sil   <= n_sil;
            r_frame <= n_frame;
            r_start <= n_start;
            r_end   <= n_end;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_seg_start <= SEG_W'(e_start);
            r_seg_end   <= SEG_W'(e_end);
            r_seg_cause <= e_cause;
        end
    end

endmodule

// ===== sv/vad_hysteresis_segmenter.sv =====
// Top level of the VAD hysteresis segmenter: configuration registers, front end,
// queue and segment machine. Depends on vhs_pkg, vhs_if, vhs_front, vhs_queue, vhs_back.
//
//   channel  dir  payload                         beat when
//   i_in     in   req_type, prob                  valid && ready
//   o_out    out  seg_start, seg_end, seg_cause   valid && ready
//   i_cfg    in   index, data                     valid && ready (ready always high)
//
// A flush, or a frame with smoothing off, goes into the queue in the cycle it is accepted and is
// decided when the segment machine pops it. A smoothed frame is summed with one history read
// per entry, then divided at one quotient bit per cycle, before it goes into the queue.
// Reset is synchronous, active low; it restores register defaults and clears the machine.
// A stalled result is held in the output register while the queue takes two more beats.
module vad_hysteresis_segmenter import vhs_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int FRAME_BITS = DEF_FRAME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vhs_in_if.sink    i_in,
    vhs_out_if.source o_out,
    vhs_cfg_if.sink   i_cfg
);

    t_vhs_cfg  r_cfg;
    t_vhs_item in_item;
    t_vhs_item push_item;
    t_vhs_item q_item;
    logic      push;
    logic      full;
    logic      pop;
    logic      q_valid;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_threshold   <= RST_ENTER_THR;
            r_cfg.exit_threshold    <= RST_EXIT_THR;
            r_cfg.smooth_window     <= RST_SMOOTH_WIN;
            r_cfg.hangover_frames   <= RST_HANGOVER;
            r_cfg.min_speech_frames <= RST_MIN_SPEECH;
            r_cfg.max_speech_frames <= RST_MAX_SPEECH;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ENTER_THR:  r_cfg.enter_threshold   <= i_cfg.data[PROB_W-1:0];
                REG_EXIT_THR:   r_cfg.exit_threshold    <= i_cfg.data[PROB_W-1:0];
                REG_SMOOTH_WIN: r_cfg.smooth_window     <= i_cfg.data[WIN_W-1:0];
                REG_HANGOVER:   r_cfg.hangover_frames   <= i_cfg.data[HANG_W-1:0];
                REG_MIN_SPEECH: r_cfg.min_speech_frames <= i_cfg.data[MINLEN_W-1:0];
                REG_MAX_SPEECH: r_cfg.max_speech_frames <= i_cfg.data[MAXLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.req_type = i_in.req_type;
    assign in_item.prob     = i_in.prob;

    vhs_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in.valid),
        .i_item      (in_item),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_push_item (push_item),
        .i_full      (full)
    );

    vhs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_item      (q_item)
    );

    vhs_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_seg_start (o_out.seg_start),
        .o_seg_end   (o_out.seg_end),
        .o_seg_cause (o_out.seg_cause)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for vad_hysteresis_segmenter: directed table, then random speech bursts.
// Depends on vhs_pkg, the channel interfaces in vhs_if and the segmenter RTL.
module tb_top import vhs_pkg::*; ();

    localparam int          SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          PHASE_ITEMS   = 125;
    localparam int          N_DIRECTED    = 40;
    localparam int          N_PHASES      = 6;
    localparam int          PROB_TOP      = 8191;

    typedef enum logic [1:0] {ST_SILENCE, ST_SPEECH, ST_TRAILING} t_vad_state;

    typedef struct packed {
        logic [SEG_W-1:0]   seg_start;
        logic [SEG_W-1:0]   seg_end;
        logic [CAUSE_W-1:0] seg_cause;
    } t_segment;

    // Expectation attached to one item: either fixed by hand or left to the predictor
    typedef struct packed {
        logic     fixed;
        logic     has_seg;
        t_segment seg;
    } t_known;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PRED, ROW_NONE, ROW_SEG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  req;
        logic [PROB_W-1:0]     prob;
        t_segment              seg;
    } t_row;

    localparam t_segment NO_SEG         = '0;
    localparam t_known   FROM_PREDICTOR = '0;

    // Directed part: register writes, extremes and every special case
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ROW_NONE,  REG_ENTER_THR,  20'd0,       REQ_FLUSH, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd8191, NO_SEG},
        '{ROW_NONE,  REG_ENTER_THR,  20'd0,       REQ_FLUSH, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_MIN_SPEECH, 20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_HANGOVER,   20'd1,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd4096, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd4095, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd1433, NO_SEG},
        '{ROW_SEG,   REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,
          '{32'd2, 32'd4, CAUSE_HANGOVER}},
        '{ROW_NONE,  REG_ENTER_THR,  20'd0,       REQ_FLUSH, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_MAX_SPEECH, 20'd3,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_ENTER_THR,  20'd4096,    REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_EXIT_THR,   20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd4095, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd4096, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_SEG,   REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,
          '{32'd7, 32'd10, CAUSE_MAXLEN}},
        '{ROW_SEG,   REG_ENTER_THR,  20'd0,       REQ_FLUSH, 13'd0,
          '{32'd10, 32'd11, CAUSE_FLUSH}},
        '{ROW_WRITE, REG_MAX_SPEECH, 20'd1048575, REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_EXIT_THR,   20'd1434,    REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_SMOOTH_WIN, 20'd20,      REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_HANGOVER,   20'd65535,   REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_MIN_SPEECH, 20'd65535,   REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd8191, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_NONE,  REG_ENTER_THR,  20'd0,       REQ_FLUSH, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_SMOOTH_WIN, 20'd3,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_MIN_SPEECH, 20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_HANGOVER,   20'd0,       REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_WRITE, REG_ENTER_THR,  20'd2048,    REQ_FRAME, 13'd0,    NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd4096, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FRAME, 13'd4096, NO_SEG},
        '{ROW_PRED,  REG_ENTER_THR,  20'd0,       REQ_FLUSH, 13'd0,    NO_SEG}
    };

    // Register settings of the random phases: enter, exit, window, hangover, min, max
    localparam t_vhs_cfg PHASE_CFG [N_PHASES] = '{
        '{13'd2048, 13'd1434, 5'd0,  16'd3, 16'd5,  20'd0},
        '{13'd3000, 13'd1000, 5'd4,  16'd0, 16'd0,  20'd40},
        '{13'd4096, 13'd4096, 5'd16, 16'd2, 16'd10, 20'd0},
        '{13'd1500, 13'd1200, 5'd8,  16'd5, 16'd3,  20'd1},
        '{13'd0,    13'd4096, 5'd2,  16'd1, 16'd1,  20'd1048575},
        '{13'd2048, 13'd1434, 5'd31, 16'd0, 16'd25, 20'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    vhs_in_if  in_ch ();
    vhs_out_if out_ch ();
    vhs_cfg_if cfg_ch ();

    vad_hysteresis_segmenter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Predictor state, starting from the reset values
    t_vhs_cfg          cfg_model = '{RST_ENTER_THR, RST_EXIT_THR, RST_SMOOTH_WIN,
                                     RST_HANGOVER, RST_MIN_SPEECH, RST_MAX_SPEECH};
    t_vad_state        vad_state   = ST_SILENCE;
    logic [PROB_W-1:0] hist [DEF_MAX_WINDOW];
    int unsigned       hist_fill   = 0;
    int unsigned       hist_next   = 0;
    logic [HANG_W-1:0] silence_run = '0;
    logic [SEG_W-1:0]  frame_idx   = '0;
    logic [SEG_W-1:0]  seg_first   = '0;
    logic [SEG_W-1:0]  seg_last    = '0;

    t_segment    segment_q [$];
    t_known      known_q [$];
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Stall the result channel at random
    always @(posedge i_clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Work out the segment, if any, that one accepted item closes
    function automatic void predict_segment(input logic req, input logic [PROB_W-1:0] p,
                                            output logic has, output t_segment seg);
        logic [PROB_W-1:0] level;
        logic [16:0]       total;
        logic [SEG_W-1:0]  now;
        logic [SEG_W-1:0]  span;
        logic [HANG_W-1:0] limit;
        logic              active;
        int unsigned       win, n, k, idx;
        has = 1'b0;
        seg = NO_SEG;
        // Flush closes an open segment and counts no frame
        if (req == REQ_FLUSH) begin
            if (vad_state != ST_SILENCE) begin
                span = frame_idx - seg_first;
                if (span >= SEG_W'(cfg_model.min_speech_frames)) begin
                    has = 1'b1;
                    seg = '{seg_first, frame_idx, CAUSE_FLUSH};
                end
                vad_state = ST_SILENCE;
            end
            return;
        end
        // Moving average over the newest entries, window capped at the store size
        win = cfg_model.smooth_window;
        if (win <= 1) begin
            level = p;
        end else begin
            if (win > DEF_MAX_WINDOW) win = DEF_MAX_WINDOW;
            hist[hist_next] = p;
            hist_next = (hist_next + 1) % DEF_MAX_WINDOW;
            n = hist_fill + 1;
            if (n > win) n = win;
            hist_fill = n;
            total = '0;
            idx = hist_next;
            for (k = 0; k < n; k++) begin
                idx = (idx + DEF_MAX_WINDOW - 1) % DEF_MAX_WINDOW;
                total = total + 17'(hist[idx]);
            end
            level = PROB_W'(32'(total) / n);
        end
        now = frame_idx;
        active = (vad_state == ST_SILENCE) ? (level >= cfg_model.enter_threshold)
                                           : (level >= cfg_model.exit_threshold);
        limit = (cfg_model.hangover_frames != '0) ? cfg_model.hangover_frames
                                                  : DEFAULT_HANGOVER;
        // Split overlong speech regardless of the minimum length
        span = now - seg_first;
        if (vad_state == ST_SPEECH && cfg_model.max_speech_frames != '0 &&
            span >= SEG_W'(cfg_model.max_speech_frames)) begin
            has = 1'b1;
            seg = '{seg_first, now, CAUSE_MAXLEN};
            seg_first = now;
            seg_last = now;
        end
        case (vad_state)
            ST_SILENCE: begin
                if (active) begin
                    vad_state = ST_SPEECH;
                    seg_first = now;
                    silence_run = '0;
                end
            end
            ST_SPEECH: begin
                if (!active) begin
                    vad_state = ST_TRAILING;
                    silence_run = HANG_W'(1);
                end
                seg_last = now;
            end
            default: begin
                if (active) begin
                    vad_state = ST_SPEECH;
                    silence_run = '0;
                end else begin
                    if (silence_run != '1) silence_run = silence_run + 1'b1;
                    if (silence_run >= limit) begin
                        span = seg_last - seg_first;
                        if (span >= SEG_W'(cfg_model.min_speech_frames)) begin
                            has = 1'b1;
                            seg = '{seg_first, seg_last, CAUSE_HANGOVER};
                        end
                        vad_state = ST_SILENCE;
                    end
                end
            end
        endcase
        frame_idx = frame_idx + 1'b1;
    endfunction

    // Track register writes, predict on input beats, check result beats
    always @(posedge i_clk) begin : check_beats
        t_known   note;
        t_segment pred;
        t_segment want;
        logic     has;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_ENTER_THR:  cfg_model.enter_threshold   = cfg_ch.data[PROB_W-1:0];
                    REG_EXIT_THR:   cfg_model.exit_threshold    = cfg_ch.data[PROB_W-1:0];
                    REG_SMOOTH_WIN: cfg_model.smooth_window     = cfg_ch.data[WIN_W-1:0];
                    REG_HANGOVER:   cfg_model.hangover_frames   = cfg_ch.data[HANG_W-1:0];
                    REG_MIN_SPEECH: cfg_model.min_speech_frames = cfg_ch.data[MINLEN_W-1:0];
                    REG_MAX_SPEECH: cfg_model.max_speech_frames = cfg_ch.data[MAXLEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                note = known_q.pop_front();
                predict_segment(in_ch.req_type, in_ch.prob, has, pred);
                if (note.fixed) begin
                    has = note.has_seg;
                    pred = note.seg;
                end
                if (has) segment_q = {segment_q, pred};
            end
            if (out_ch.valid && out_ch.ready) begin
                if (segment_q.size() == 0) begin
                    $error("unexpected segment: start %0d end %0d cause %0d",
                           out_ch.seg_start, out_ch.seg_end, out_ch.seg_cause);
                    fail_count++;
                end else begin
                    want = segment_q.pop_front();
                    if (out_ch.seg_start !== want.seg_start) begin
                        $error("seg_start mismatch: expected %0d, got %0d",
                               want.seg_start, out_ch.seg_start);
                        fail_count++;
                    end
                    if (out_ch.seg_end !== want.seg_end) begin
                        $error("seg_end mismatch: expected %0d, got %0d",
                               want.seg_end, out_ch.seg_end);
                        fail_count++;
                    end
                    if (out_ch.seg_cause !== want.seg_cause) begin
                        $error("seg_cause mismatch: expected %0d, got %0d",
                               want.seg_cause, out_ch.seg_cause);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Offer one item; valid stays high after the beat so back-to-back items need no gap
    task automatic send_item(input logic req, input logic [PROB_W-1:0] p, input t_known note);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        known_q = {known_q, note};
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.prob     <= p;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // Write one register; the caller drops valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // Drop input valid, wait for every expected segment, then let in-flight frames finish
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (segment_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input t_vhs_cfg c);
        wait_idle();
        write_reg(REG_ENTER_THR,  CFG_DATA_W'(c.enter_threshold));
        write_reg(REG_EXIT_THR,   CFG_DATA_W'(c.exit_threshold));
        write_reg(REG_SMOOTH_WIN, CFG_DATA_W'(c.smooth_window));
        write_reg(REG_HANGOVER,   CFG_DATA_W'(c.hangover_frames));
        write_reg(REG_MIN_SPEECH, CFG_DATA_W'(c.min_speech_frames));
        write_reg(REG_MAX_SPEECH, CFG_DATA_W'(c.max_speech_frames));
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly speech bursts followed by silence near the hangover length, some noise
    task automatic run_random(input int unsigned n_items);
        int unsigned sent, burst, quiet, k, floor_hi, quiet_max;
        logic [PROB_W-1:0] p;
        sent = 0;
        while (sent < n_items) begin
            floor_hi = (cfg_model.enter_threshold > cfg_model.exit_threshold) ?
                       cfg_model.enter_threshold : cfg_model.exit_threshold;
            quiet_max = (cfg_model.hangover_frames != '0) ? cfg_model.hangover_frames
                                                          : DEFAULT_HANGOVER;
            if ($urandom_range(99) < 85) begin
                burst = $urandom_range(1, 40);
                quiet = $urandom_range(0, quiet_max + 4);
                for (k = 0; k < burst + quiet; k++) begin
                    if (k < burst && $urandom_range(99) >= 10)
                        p = PROB_W'($urandom_range(floor_hi, PROB_TOP));
                    else if (cfg_model.exit_threshold == '0)
                        p = '0;
                    else
                        p = PROB_W'($urandom_range(0, cfg_model.exit_threshold - 1));
                    send_item(REQ_FRAME, p, FROM_PREDICTOR);
                end
                sent += burst + quiet;
                if ($urandom_range(99) < 15) begin
                    send_item(REQ_FLUSH, PROB_W'($urandom_range(0, PROB_TOP)), FROM_PREDICTOR);
                    sent++;
                end
            end else begin
                for (k = $urandom_range(1, 8); k > 0; k--) begin
                    send_item(($urandom_range(99) < 10) ? REQ_FLUSH : REQ_FRAME,
                              PROB_W'($urandom_range(0, PROB_TOP)), FROM_PREDICTOR);
                    sent++;
                end
            end
        end
    endtask

    // Timeout
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_known note;
        int     ph;
        in_ch.valid    = 1'b0;
        in_ch.req_type = REQ_FRAME;
        in_ch.prob     = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_ENTER_THR;
        cfg_ch.data    = '0;
        out_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 77;

        // Walk the directed table; writes wait for the block to go idle
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                if (!cfg_ch.valid) wait_idle();
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value);
            end else begin
                cfg_ch.valid <= 1'b0;
                case (DIRECTED[r].kind)
                    ROW_NONE: note = '{1'b1, 1'b0, NO_SEG};
                    ROW_SEG:  note = '{1'b1, 1'b1, DIRECTED[r].seg};
                    default:  note = FROM_PREDICTOR;
                endcase
                send_item(DIRECTED[r].req, DIRECTED[r].prob, note);
            end
        end

        // Random phases: two per idling pattern
        for (ph = 0; ph < N_PHASES; ph++) begin
            set_config(PHASE_CFG[ph]);
            case (ph / 2)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
sv/vhs_pkg.sv
sv/vhs_if.sv
sv/vhs_front.sv
sv/vhs_queue.sv
sv/vhs_back.sv
sv/vad_hysteresis_segmenter.sv
test/tb_top.sv
